// ===== hw/rtl/assert_macros.svh =====
// Assertion helper macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/plob_pkg.sv =====
// ----------------------------------------------------------------------------
// plob_pkg
// Types and codes for the price-level order book.
// ----------------------------------------------------------------------------
`default_nettype none

package plob_pkg;

   typedef struct packed {
      logic [5:0]  symbol;
      logic        side;
      logic [31:0] price;
      logic [31:0] quantity;
   } req_type;

   typedef struct packed {
      logic [2:0]  outcome;
      logic [4:0]  side_depth;
      logic        has_bid;
      logic [31:0] best_bid_price;
      logic [31:0] best_bid_size;
      logic        has_ask;
      logic [31:0] best_ask_price;
      logic [31:0] best_ask_size;
   } rsp_type;

   typedef enum logic [2:0] {
      OC_DELETED     = 3'd0,
      OC_UPDATED     = 3'd1,
      OC_INSERTED    = 3'd2,
      OC_EVICTED     = 3'd3,
      OC_DEL_MISSING = 3'd4,
      OC_DROPPED     = 3'd5
   } outcome_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_TOP,
      ST_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;   // capture request word, start row read
      logic eval;   // search row and work out new row
      logic top;    // read best levels of both sides
      logic fill;   // build response word
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_of_range;
   } sts_type;

endpackage

`default_nettype wire

// ===== hw/rtl/price_level_order_book_core.sv =====
// ----------------------------------------------------------------------------
// price_level_order_book_core
// Depth-limited price-level book per symbol and side, one response per word.
//
//   channel   direction   payload
//   req_      in          symbol, side, price, quantity
//   rsp_      out         outcome, side_depth, best bid and ask
//
// Each word passes through these steps in order: capture, row read,
// compare-and-shift with write back, best-level read, response register.
// A new word is taken only once the previous response is registered.
// Reset clears all side depths at once; no clearing pass.
// A stalled response holds the block in its last step; no new word is taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module price_level_order_book_core #(
   parameter int MAX_LEVELS  = 16,
   parameter int NUM_SYMBOLS = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire plob_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output plob_pkg::rsp_type      rsp_data
);

   plob_pkg::cmd_type cmd;
   plob_pkg::sts_type sts;

   plob_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   plob_datapath #(
      .MAX_LEVELS  (MAX_LEVELS),
      .NUM_SYMBOLS (NUM_SYMBOLS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_word (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_word (rsp_data)
   );

   // depth never exceeds the configured row length
   `ASSERT_IMPL(a_depth, clock, reset, rsp_valid, rsp_data.side_depth <= 5'(MAX_LEVELS), "depth")
   // outcome codes stay within the defined set
   `ASSERT_IMPL(a_code, clock, reset, rsp_valid, rsp_data.outcome <= plob_pkg::OC_DROPPED, "bad outcome")
   // a word accepted produces the load command in the same cycle
   `ASSERT_IMPL(a_load, clock, reset, req_valid && req_ready, cmd.load, "accept without load")
   // after a load the block takes no further word next cycle
   `ASSERT_NEXT(a_busy, clock, reset, cmd.load, !req_ready, "ready while busy")

endmodule

`default_nettype wire

// ===== hw/rtl/plob_ctrl.sv =====
// ----------------------------------------------------------------------------
// plob_ctrl
// Sequencer: load, row read, evaluate and write back, top read, respond.
// ----------------------------------------------------------------------------
`default_nettype none

module plob_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output plob_pkg::cmd_type      cmd,
   input  wire plob_pkg::sts_type sts
);

   plob_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= plob_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         plob_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = plob_pkg::ST_READ;
            end
         end
         plob_pkg::ST_READ: begin
            state_in = plob_pkg::ST_EVAL;
         end
         plob_pkg::ST_EVAL: begin
            cmd.eval = !sts.out_of_range;
            state_in = plob_pkg::ST_TOP;
         end
         plob_pkg::ST_TOP: begin
            cmd.top  = 1'b1;
            state_in = plob_pkg::ST_OUT;
         end
         plob_pkg::ST_OUT: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.fill     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = plob_pkg::ST_IDLE;
            end
         end
         default: state_in = plob_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/plob_datapath.sv =====
// ----------------------------------------------------------------------------
// plob_datapath
// Row store, depth counts, compare-and-shift over one side row, response.
// ----------------------------------------------------------------------------
`default_nettype none

module plob_datapath #(
   parameter int MAX_LEVELS  = 16,
   parameter int NUM_SYMBOLS = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire plob_pkg::req_type req_word,
   input  wire plob_pkg::cmd_type cmd,
   output plob_pkg::sts_type      sts,
   output plob_pkg::rsp_type      rsp_word
);

   localparam int ROWS = NUM_SYMBOLS * 2;
   localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CW   = $clog2(MAX_LEVELS + 1);
   localparam int IW   = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
   localparam int SW   = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;

   typedef logic [MAX_LEVELS-1:0][31:0] row_type;

   // row memories: one word holds a whole side row
   row_type mem_px [ROWS];
   row_type mem_sz [ROWS];

   logic [ROWS-1:0]   cnt_valid_ff;
   logic [CW-1:0]     cnt_ff [ROWS];

   plob_pkg::req_type rq_ff;
   logic              oor_ff;
   logic [RW-1:0]     row_ff;
   row_type           rpx_ff, rsz_ff;
   logic [CW-1:0]     n_ff;
   logic [2:0]        oc_ff, oc_in;
   logic [CW-1:0]     nn_ff, nn_in;
   logic [31:0]       own_px_ff, own_sz_ff;
   logic [31:0]       bbp_ff, bbs_ff, bap_ff, bas_ff;
   logic              hb_ff, ha_ff;
   plob_pkg::rsp_type rsp_ff;

   logic [RW-1:0]     row_in;
   logic              oor_in;
   row_type           npx, nsz;
   logic              wr_en;

   // request capture and row address
   always_comb begin
      oor_in = ({26'd0, req_word.symbol} >= 32'(NUM_SYMBOLS));
      row_in = RW'({req_word.symbol[SW-1:0], req_word.side});
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rq_ff  <= req_word;
         oor_ff <= oor_in;
         row_ff <= row_in;
      end
   end

   assign sts.out_of_range = oor_ff;

   // row read, registered
   always_ff @(posedge clock) begin
      rpx_ff <= mem_px[row_ff];
      rsz_ff <= mem_sz[row_ff];
      n_ff   <= cnt_valid_ff[row_ff] ? cnt_ff[row_ff] : '0;
   end

   // compare-and-shift over the row
   always_comb begin
      logic [MAX_LEVELS-1:0] inr, bet, eqp;
      logic [CW-1:0]         idx, nc;
      logic                  found, full;
      idx = '0;
      for (int k = 0; k < MAX_LEVELS; k++) begin
         inr[k] = (CW'(k) < n_ff);
         bet[k] = rq_ff.side ? (rpx_ff[k] < rq_ff.price) : (rpx_ff[k] > rq_ff.price);
         eqp[k] = (rpx_ff[k] == rq_ff.price);
         // sorted row: position is count of better live entries
         idx = idx + CW'(inr[k] & bet[k]);
      end
      found = 1'b0;
      for (int k = 0; k < MAX_LEVELS; k++)
         if (CW'(k) == idx && inr[k] && eqp[k]) found = 1'b1;
      full  = (n_ff == CW'(MAX_LEVELS));
      npx   = rpx_ff;
      nsz   = rsz_ff;
      nc    = n_ff;
      wr_en = 1'b0;
      if (rq_ff.quantity == 32'd0) begin
         if (!found) begin
            oc_in = plob_pkg::OC_DEL_MISSING;
         end else begin
            for (int k = 0; k < MAX_LEVELS - 1; k++)
               if (CW'(k) >= idx) begin
                  npx[k] = rpx_ff[k+1];
                  nsz[k] = rsz_ff[k+1];
               end
            nc    = n_ff - CW'(1);
            oc_in = plob_pkg::OC_DELETED;
            wr_en = 1'b1;
         end
      end else if (found) begin
         for (int k = 0; k < MAX_LEVELS; k++)
            if (CW'(k) == idx) nsz[k] = rq_ff.quantity;
         oc_in = plob_pkg::OC_UPDATED;
         wr_en = 1'b1;
      end else if (full && idx == n_ff) begin
         oc_in = plob_pkg::OC_DROPPED;
      end else begin
         oc_in = full ? plob_pkg::OC_EVICTED : plob_pkg::OC_INSERTED;
         nc    = full ? n_ff : n_ff + CW'(1);
         for (int k = 1; k < MAX_LEVELS; k++)
            if (CW'(k) > idx) begin
               npx[k] = rpx_ff[k-1];
               nsz[k] = rsz_ff[k-1];
            end
         for (int k = 0; k < MAX_LEVELS; k++)
            if (CW'(k) == idx) begin
               npx[k] = rq_ff.price;
               nsz[k] = rq_ff.quantity;
            end
         wr_en = 1'b1;
      end
      nn_in = nc;
   end

   // row write back
   always_ff @(posedge clock) begin
      if (cmd.eval && wr_en) begin
         mem_px[row_ff] <= npx;
         mem_sz[row_ff] <= nsz;
      end
   end

   // depth counts with valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_valid_ff <= '0;
      end else if (cmd.eval) begin
         cnt_valid_ff[row_ff] <= 1'b1;
      end
   end

   // new depth, outcome and best level of the updated side
   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         cnt_ff[row_ff] <= nn_in;
         oc_ff          <= oc_in;
         nn_ff          <= nn_in;
         own_px_ff      <= npx[0];
         own_sz_ff      <= nsz[0];
      end
   end

   // best levels of both sides; the other side is read after write back
   always_ff @(posedge clock) begin
      logic [RW-1:0] ro;
      row_type       op, os;
      logic          oh;
      ro = {row_ff[RW-1:1], ~row_ff[0]};
      op = mem_px[ro];
      os = mem_sz[ro];
      oh = cnt_valid_ff[ro] && (cnt_ff[ro] != '0);
      if (cmd.top) begin
         if (row_ff[0]) begin
            // ask side updated
            hb_ff  <= oh;
            bbp_ff <= op[0];
            bbs_ff <= os[0];
            ha_ff  <= (nn_ff != '0);
            bap_ff <= own_px_ff;
            bas_ff <= own_sz_ff;
         end else begin
            // bid side updated
            hb_ff  <= (nn_ff != '0);
            bbp_ff <= own_px_ff;
            bbs_ff <= own_sz_ff;
            ha_ff  <= oh;
            bap_ff <= op[0];
            bas_ff <= os[0];
         end
      end
   end

   // response word
   always_ff @(posedge clock) begin
      if (cmd.fill) begin
         if (oor_ff) begin
            rsp_ff         <= '0;
            rsp_ff.outcome <= plob_pkg::OC_DROPPED;
         end else begin
            rsp_ff.outcome        <= oc_ff;
            rsp_ff.side_depth     <= 5'(nn_ff);
            rsp_ff.has_bid        <= hb_ff;
            rsp_ff.best_bid_price <= hb_ff ? bbp_ff : 32'd0;
            rsp_ff.best_bid_size  <= hb_ff ? bbs_ff : 32'd0;
            rsp_ff.has_ask        <= ha_ff;
            rsp_ff.best_ask_price <= ha_ff ? bap_ff : 32'd0;
            rsp_ff.best_ask_size  <= ha_ff ? bas_ff : 32'd0;
         end
      end
   end

   assign rsp_word = rsp_ff;

endmodule

`default_nettype wire

// ===== verif/price_level_order_book_core_test.sv =====
// ----------------------------------------------------------------------------
// price_level_order_book_core_test
// Self-checking bench for the price-level book: directed words at the field
// extremes and each outcome, then random update traffic with random gaps on
// both channels; every response is compared with a predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module price_level_order_book_core_test;

   localparam int DEPTH   = 16;
   localparam int SYMS    = 64;
   localparam int N_RAND  = 1850;
   localparam int WD_MAX  = 20000;

   // scoreboard: own copy of every book row, queue of expected responses
   class book_scoreboard;
      logic [31:0]       px [SYMS*2][DEPTH];
      logic [31:0]       sz [SYMS*2][DEPTH];
      int                cnt [SYMS*2];
      plob_pkg::rsp_type pending [$];
      int                n_errors;
      int                n_checked;
      int                oc_seen [6];

      function void clear();
         foreach (cnt[r]) cnt[r] = 0;
         n_errors = 0;
         n_checked = 0;
         foreach (oc_seen[k]) oc_seen[k] = 0;
      endfunction

      function void note_word(plob_pkg::req_type w);
         plob_pkg::rsp_type     e;
         int                    row, n, i, k;
         bit                    found;
         plob_pkg::outcome_type oc;
         e = '0;
         if (w.symbol >= SYMS) begin
            e.outcome = plob_pkg::OC_DROPPED;
            pending.push_back(e);
            return;
         end
         row = w.symbol * 2 + w.side;
         n = cnt[row];
         i = 0;
         while (i < n && (w.side ? px[row][i] < w.price : px[row][i] > w.price)) i++;
         found = (i < n) && (px[row][i] == w.price);
         if (w.quantity == 0) begin
            if (!found) oc = plob_pkg::OC_DEL_MISSING;
            else begin
               for (k = i; k + 1 < n; k++) begin
                  px[row][k] = px[row][k+1];
                  sz[row][k] = sz[row][k+1];
               end
               n--;
               oc = plob_pkg::OC_DELETED;
            end
         end else if (found) begin
            sz[row][i] = w.quantity;
            oc = plob_pkg::OC_UPDATED;
         end else if (n == DEPTH && i == n) begin
            oc = plob_pkg::OC_DROPPED;
         end else begin
            oc = plob_pkg::OC_INSERTED;
            if (n == DEPTH) begin
               n--;
               oc = plob_pkg::OC_EVICTED;
            end
            for (k = n; k > i; k--) begin
               px[row][k] = px[row][k-1];
               sz[row][k] = sz[row][k-1];
            end
            px[row][i] = w.price;
            sz[row][i] = w.quantity;
            n++;
         end
         cnt[row] = n;
         e.outcome = oc;
         e.side_depth = n[4:0];
         if (cnt[w.symbol*2] > 0) begin
            e.has_bid = 1'b1;
            e.best_bid_price = px[w.symbol*2][0];
            e.best_bid_size = sz[w.symbol*2][0];
         end
         if (cnt[w.symbol*2+1] > 0) begin
            e.has_ask = 1'b1;
            e.best_ask_price = px[w.symbol*2+1][0];
            e.best_ask_size = sz[w.symbol*2+1][0];
         end
         pending.push_back(e);
      endfunction

      function void check_word(plob_pkg::rsp_type a);
         plob_pkg::rsp_type e;
         if (pending.size() == 0) begin
            $error("unexpected response word %h", a);
            n_errors++;
            return;
         end
         e = pending.pop_front();
         n_checked++;
         if (e.outcome < 6) oc_seen[e.outcome]++;
         if (a.outcome !== e.outcome) begin
            $error("outcome: expected %0d, got %0d", e.outcome, a.outcome); n_errors++;
         end
         if (a.side_depth !== e.side_depth) begin
            $error("side_depth: expected %0d, got %0d", e.side_depth, a.side_depth);
            n_errors++;
         end
         if (a.has_bid !== e.has_bid) begin
            $error("has_bid: expected %0d, got %0d", e.has_bid, a.has_bid); n_errors++;
         end
         if (a.best_bid_price !== e.best_bid_price) begin
            $error("best_bid_price: expected %h, got %h", e.best_bid_price,
                   a.best_bid_price);
            n_errors++;
         end
         if (a.best_bid_size !== e.best_bid_size) begin
            $error("best_bid_size: expected %h, got %h", e.best_bid_size,
                   a.best_bid_size);
            n_errors++;
         end
         if (a.has_ask !== e.has_ask) begin
            $error("has_ask: expected %0d, got %0d", e.has_ask, a.has_ask); n_errors++;
         end
         if (a.best_ask_price !== e.best_ask_price) begin
            $error("best_ask_price: expected %h, got %h", e.best_ask_price,
                   a.best_ask_price);
            n_errors++;
         end
         if (a.best_ask_size !== e.best_ask_size) begin
            $error("best_ask_size: expected %h, got %h", e.best_ask_size,
                   a.best_ask_size);
            n_errors++;
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   plob_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   plob_pkg::rsp_type rsp_data;

   book_scoreboard sb;
   int  idle_cycles;
   int  stall_left;
   bit  stim_done;
   bit  rsp_hold_free;

   price_level_order_book_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0; #6;
      clock = 1'b1; #6;
   end

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // valid stays up between back-to-back words; dropped only for a gap
   task automatic send_word(plob_pkg::req_type w);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_word(w);
   endtask

   // stop sending and wait for every outstanding response
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   task automatic send(int sym, int sd, logic [31:0] p, logic [31:0] q);
      plob_pkg::req_type w;
      w.symbol = 6'(sym);
      w.side = 1'(sd);
      w.price = p;
      w.quantity = q;
      send_word(w);
   endtask

   // bias prices into a narrow band so updates and deletes hit levels
   function automatic plob_pkg::req_type rand_word(int sym_hi);
      plob_pkg::req_type w;
      int                r;
      w.symbol = 6'($urandom_range(0, sym_hi));
      w.side = 1'($urandom_range(0, 1));
      r = $urandom_range(0, 99);
      if (r < 85) w.price = 32'h8000_0000 + $urandom_range(0, 40);
      else w.price = $urandom;
      r = $urandom_range(0, 99);
      if (r < 25) w.quantity = 32'd0;
      else if (r < 35) w.quantity = 32'hFFFF_FFFF;
      else w.quantity = $urandom;
      return w;
   endfunction

   // response side: random stalls, a few long ones, with stretches of no stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) sb.check_word(rsp_data);
         if (rsp_hold_free) begin
            rsp_ready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_ready  <= 1'b0;
            stall_left <= stall_left - 1;
         end else if ($urandom_range(0, 99) < 3) begin
            rsp_ready  <= 1'b0;
            stall_left <= $urandom_range(10, 40);
         end else begin
            rsp_ready <= ($urandom_range(0, 99) < 70) ||
                         ($urandom_range(0, 9) == 0 && rsp_ready);
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (!stim_done || sb.pending.size() > 0) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WD_MAX) begin
            $display("watchdog: no handshake for %0d cycles", WD_MAX);
            $display("price_level_order_book_core_test: errors");
            $finish;
         end
      end
   end

   initial begin
      int k, wait_cnt;
      sb = new();
      sb.clear();
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      stim_done = 0;
      rsp_hold_free = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes and every outcome
      send(0, 0, 32'h0000_0000, 32'h0000_0001);
      send(0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send(0, 0, 32'hFFFF_FFFF, 32'h1234_5678);
      send(0, 0, 32'h0000_0000, 0);
      send(0, 0, 32'h0000_0000, 0);
      send(63, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send(63, 1, 32'h0000_0000, 32'h0000_0001);
      send(63, 1, 32'h5555_AAAA, 32'hAAAA_5555);
      for (k = 0; k < DEPTH; k++) send(5, 1, 100 + 2 * k, k + 1);
      send(5, 1, 200, 7);
      send(5, 1, 99, 9);
      send(5, 1, 101, 0);
      send(5, 1, 99, 0);

      // sender holds off until all responses are in
      drain();

      // random: a few hot symbols so sides fill, plus whole-range words
      for (k = 0; k < N_RAND; k++) begin
         if (k == N_RAND / 2) begin
            rsp_hold_free = 1;
            drain();
         end
         if (k == N_RAND / 2 + 200) rsp_hold_free = 0;
         send_word(rand_word(($urandom_range(0, 9) < 8) ? 3 : 63));
      end
      req_valid <= 1'b0;
      stim_done = 1;

      wait_cnt = 0;
      while (sb.pending.size() > 0 && wait_cnt < WD_MAX) begin
         @(posedge clock);
         wait_cnt++;
      end
      repeat (20) @(posedge clock);

      $display("checked %0d responses: deleted %0d, updated %0d, inserted %0d,",
               sb.n_checked, sb.oc_seen[0], sb.oc_seen[1], sb.oc_seen[2]);
      $display("  evicted %0d, delete missing %0d, dropped %0d",
               sb.oc_seen[3], sb.oc_seen[4], sb.oc_seen[5]);
      if (sb.n_errors == 0 && sb.pending.size() == 0) begin
         $display("price_level_order_book_core_test: clean");
      end else begin
         if (sb.pending.size() > 0) $error("%0d responses never came", sb.pending.size());
         $display("price_level_order_book_core_test: errors");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/plob_pkg.sv
hw/rtl/plob_ctrl.sv
hw/rtl/plob_datapath.sv
hw/rtl/price_level_order_book_core.sv
verif/price_level_order_book_core_test.sv
